/* hw/rtl/pim_pkg.sv */
// Shared types and codes for the priority inheritance mutex.
package pim_pkg;

  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  localparam logic [2:0] ST_ACQUIRED  = 3'd0;
  localparam logic [2:0] ST_NESTED    = 3'd1;
  localparam logic [2:0] ST_WAITING   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_HELD      = 3'd4;
  localparam logic [2:0] ST_RELEASED  = 3'd5;
  localparam logic [2:0] ST_NOT_OWNER = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  localparam logic [7:0] DEPTH_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } pim_entry_t;

  typedef struct packed {
    logic append;
    logic remove;
  } pim_cell_ctl_t;

endpackage

/* hw/rtl/pim_cell.sv */
// One wait list cell: a stored waiter plus one stage of the travelling best-waiter search.
module pim_cell #(
  parameter int WAIT_DEPTH = 16,
  parameter int IDX = 0,
  localparam int IW = $clog2(WAIT_DEPTH),
  localparam int CW = $clog2(WAIT_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pim_pkg::pim_cell_ctl_t ctl,
  input  logic [CW-1:0]          count,
  input  logic [IW-1:0]          pick_idx,
  input  pim_pkg::pim_entry_t    new_ent,
  input  pim_pkg::pim_entry_t    nb_ent,
  output pim_pkg::pim_entry_t    ent,
  input  logic                   cand_in_vld,
  input  pim_pkg::pim_entry_t    cand_in_ent,
  input  logic [IW-1:0]          cand_in_idx,
  output logic                   cand_vld,
  output pim_pkg::pim_entry_t    cand_ent,
  output logic [IW-1:0]          cand_idx
);
  import pim_pkg::*;

  pim_entry_t    ent_r;
  logic          cand_vld_r;
  pim_entry_t    cand_ent_r;
  logic [IW-1:0] cand_idx_r;
  logic          in_range;
  logic          take_own;

  assign in_range = CW'(IDX) < count;
  // strict compare keeps the earlier waiter on a tie
  assign take_own = in_range && (!cand_in_vld || (ent_r.prio > cand_in_ent.prio));

  always_ff @(posedge clk) begin
    if (ctl.append && (CW'(IDX) == count)) begin
      ent_r <= new_ent;
    end else if (ctl.remove && (IW'(IDX) >= pick_idx)) begin
      ent_r <= nb_ent;
    end
    cand_ent_r <= take_own ? ent_r : cand_in_ent;
    cand_idx_r <= take_own ? IW'(IDX) : cand_in_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_r <= 1'b0;
    end else begin
      cand_vld_r <= take_own || cand_in_vld;
    end
  end

  assign ent      = ent_r;
  assign cand_vld = cand_vld_r;
  assign cand_ent = cand_ent_r;
  assign cand_idx = cand_idx_r;

endmodule

/* hw/rtl/priority_inheritance_mutex.sv */
// Recursive mutex with priority inheritance: one request in, one result out per request.
// Lock requests and unlock requests that do not hand the mutex on are answered from S_IDLE.
// A final unlock with waiters queued goes through S_SCAN and S_APPLY: the best-waiter
// candidate travels down the row of wait list cells one cell per cycle, then the chosen
// waiter is removed (the cells behind it move up one place) and becomes the owner.
// A new request is taken whenever the controller is idle and the result register is
// empty or being emptied in that cycle.
module priority_inheritance_mutex #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_task_id,
  input  logic [7:0] in_task_priority,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic       out_wake_valid,
  output logic [7:0] out_wake_task,
  output logic       out_boost_valid,
  output logic [7:0] out_boost_task,
  output logic [7:0] out_boost_priority,
  output logic [7:0] out_nest_depth
);
  import pim_pkg::*;

  localparam int IW = $clog2(WAIT_DEPTH);
  localparam int CW = $clog2(WAIT_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t        state_r;
  logic [IW-1:0] scan_cnt_r;
  logic          owner_valid_r;
  logic [7:0]    owner_task_r;
  logic [7:0]    owner_prio_r;
  logic [7:0]    hold_depth_r;
  logic [CW-1:0] count_r;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic          out_wake_valid_r;
  logic [7:0]    out_wake_task_r;
  logic          out_boost_valid_r;
  logic [7:0]    out_boost_task_r;
  logic [7:0]    out_boost_priority_r;
  logic [7:0]    out_nest_depth_r;

  logic          out_free;
  logic          in_accept;
  logic          out_load;
  logic          is_owner;
  logic [7:0]    depth_dec;

  logic          owner_valid_nxt;
  logic [7:0]    owner_task_nxt;
  logic [7:0]    owner_prio_nxt;
  logic [7:0]    hold_depth_nxt;
  logic [CW-1:0] count_nxt;
  logic [2:0]    dec_status;
  logic          dec_boost;
  logic          dec_append;
  logic          dec_scan;

  pim_cell_ctl_t cell_ctl;
  pim_entry_t    new_ent;
  pim_entry_t    ent_w      [WAIT_DEPTH];
  logic          cand_vld_w [WAIT_DEPTH];
  pim_entry_t    cand_ent_w [WAIT_DEPTH];
  logic [IW-1:0] cand_idx_w [WAIT_DEPTH];
  pim_entry_t    best_ent;
  logic [IW-1:0] best_idx;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  // a new result enters the output register at this edge
  assign out_load  = (in_accept && !dec_scan) || ((state_r == S_APPLY) && out_free);

  assign is_owner  = owner_valid_r && (owner_task_r == in_task_id);
  assign depth_dec = (hold_depth_r != 8'd0) ? hold_depth_r - 8'd1 : 8'd0;

  always_comb begin
    owner_valid_nxt = owner_valid_r;
    owner_task_nxt  = owner_task_r;
    owner_prio_nxt  = owner_prio_r;
    hold_depth_nxt  = hold_depth_r;
    count_nxt       = count_r;
    dec_status      = ST_NOT_OWNER;
    dec_boost       = 1'b0;
    dec_append      = 1'b0;
    dec_scan        = 1'b0;
    case (in_cmd)
      CMD_LOCK: begin
        if (is_owner) begin
          if (hold_depth_r == DEPTH_MAX) begin
            dec_status = ST_OVERFLOW;
          end else begin
            hold_depth_nxt = hold_depth_r + 8'd1;
            dec_status     = ST_NESTED;
          end
        end else if (!owner_valid_r) begin
          owner_valid_nxt = 1'b1;
          owner_task_nxt  = in_task_id;
          owner_prio_nxt  = in_task_priority;
          hold_depth_nxt  = 8'd1;
          dec_status      = ST_ACQUIRED;
        end else begin
          // boost the owner even when the requester cannot be queued
          if (in_task_priority > owner_prio_r) begin
            owner_prio_nxt = in_task_priority;
            dec_boost      = 1'b1;
          end
          if (count_r < CW'(WAIT_DEPTH)) begin
            dec_append = 1'b1;
            count_nxt  = count_r + CW'(1);
            dec_status = ST_WAITING;
          end else begin
            dec_status = ST_FULL;
          end
        end
      end
      CMD_UNLOCK: begin
        if (is_owner) begin
          hold_depth_nxt = depth_dec;
          dec_status     = ST_RELEASED;
          if (depth_dec != 8'd0) begin
            dec_status = ST_HELD;
          end else if (count_r != '0) begin
            dec_scan = 1'b1;
          end else begin
            owner_valid_nxt = 1'b0;
            owner_task_nxt  = 8'd0;
            owner_prio_nxt  = 8'd0;
          end
        end
      end
      default: begin
        dec_status = ST_NOT_OWNER;
      end
    endcase
  end

  assign new_ent.id       = in_task_id;
  assign new_ent.prio     = in_task_priority;
  assign cell_ctl.append  = in_accept && dec_append;
  assign cell_ctl.remove  = (state_r == S_APPLY) && out_free;
  assign best_ent         = cand_ent_w[WAIT_DEPTH-1];
  assign best_idx         = cand_idx_w[WAIT_DEPTH-1];

  for (genvar g = 0; g < WAIT_DEPTH; g++) begin : g_cell
    pim_entry_t    nb_ent;
    logic          cin_vld;
    pim_entry_t    cin_ent;
    logic [IW-1:0] cin_idx;

    if (g == WAIT_DEPTH - 1) begin : g_tail
      assign nb_ent = '0;
    end else begin : g_body
      assign nb_ent = ent_w[g+1];
    end

    if (g == 0) begin : g_head
      assign cin_vld = 1'b0;
      assign cin_ent = '0;
      assign cin_idx = '0;
    end else begin : g_link
      assign cin_vld = cand_vld_w[g-1];
      assign cin_ent = cand_ent_w[g-1];
      assign cin_idx = cand_idx_w[g-1];
    end

    pim_cell #(
      .WAIT_DEPTH(WAIT_DEPTH),
      .IDX       (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .count      (count_r),
      .pick_idx   (best_idx),
      .new_ent    (new_ent),
      .nb_ent     (nb_ent),
      .ent        (ent_w[g]),
      .cand_in_vld(cin_vld),
      .cand_in_ent(cin_ent),
      .cand_in_idx(cin_idx),
      .cand_vld   (cand_vld_w[g]),
      .cand_ent   (cand_ent_w[g]),
      .cand_idx   (cand_idx_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      scan_cnt_r    <= '0;
      owner_valid_r <= 1'b0;
      owner_task_r  <= 8'd0;
      owner_prio_r  <= 8'd0;
      hold_depth_r  <= 8'd0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (dec_scan) begin
              // hold the owner until the best waiter reaches the tail cell
              state_r    <= S_SCAN;
              scan_cnt_r <= '0;
            end else begin
              owner_valid_r        <= owner_valid_nxt;
              owner_task_r         <= owner_task_nxt;
              owner_prio_r         <= owner_prio_nxt;
              hold_depth_r         <= hold_depth_nxt;
              count_r              <= count_nxt;
              out_valid_r          <= 1'b1;
              out_status_r         <= dec_status;
              out_wake_valid_r     <= 1'b0;
              out_wake_task_r      <= 8'd0;
              out_boost_valid_r    <= dec_boost;
              out_boost_task_r     <= dec_boost ? owner_task_r : 8'd0;
              out_boost_priority_r <= dec_boost ? in_task_priority : 8'd0;
              out_nest_depth_r     <= hold_depth_nxt;
            end
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + IW'(1);
          if (scan_cnt_r == IW'(WAIT_DEPTH - 1)) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            owner_valid_r        <= 1'b1;
            owner_task_r         <= best_ent.id;
            owner_prio_r         <= best_ent.prio;
            hold_depth_r         <= 8'd1;
            count_r              <= count_r - CW'(1);
            out_valid_r          <= 1'b1;
            out_status_r         <= ST_RELEASED;
            out_wake_valid_r     <= 1'b1;
            out_wake_task_r      <= best_ent.id;
            out_boost_valid_r    <= 1'b0;
            out_boost_task_r     <= 8'd0;
            out_boost_priority_r <= 8'd0;
            out_nest_depth_r     <= 8'd1;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_wake_valid     = out_wake_valid_r;
  assign out_wake_task      = out_wake_task_r;
  assign out_boost_valid    = out_boost_valid_r;
  assign out_boost_task     = out_boost_task_r;
  assign out_boost_priority = out_boost_priority_r;
  assign out_nest_depth     = out_nest_depth_r;

endmodule

/* dv/pim_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the priority inheritance mutex: predicts every result and compares it.
module pim_result_checker #(
  parameter int WAIT_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_task_id,
  input  logic [7:0] in_task_priority,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_status,
  input  logic       out_wake_valid,
  input  logic [7:0] out_wake_task,
  input  logic       out_boost_valid,
  input  logic [7:0] out_boost_task,
  input  logic [7:0] out_boost_priority,
  input  logic [7:0] out_nest_depth,
  output int         mismatches,
  output int         outstanding,
  output int         checked
);
  import pim_pkg::*;

  typedef struct packed {
    logic [2:0] status;
    logic       wake_valid;
    logic [7:0] wake_task;
    logic       boost_valid;
    logic [7:0] boost_task;
    logic [7:0] boost_priority;
    logic [7:0] nest_depth;
  } mutex_result_t;

  logic          held;
  logic [7:0]    holder_id;
  logic [7:0]    holder_prio;
  logic [7:0]    depth;
  pim_entry_t    waiters[$];
  mutex_result_t expected_results[$];

  // Advance the mutex state by one request and return the result it should produce.
  function automatic mutex_result_t apply_request(input logic cmd, input logic [7:0] id,
                                                  input logic [7:0] prio);
    mutex_result_t r;
    logic          is_holder;
    int            best;
    r = '0;
    is_holder = held && (holder_id == id);
    if (cmd == CMD_LOCK) begin
      if (is_holder) begin
        if (depth == DEPTH_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          depth++;
          r.status = ST_NESTED;
        end
      end else if (!held) begin
        held = 1'b1;
        holder_id = id;
        holder_prio = prio;
        depth = 8'd1;
        r.status = ST_ACQUIRED;
      end else begin
        // boost the holder even when the wait list has no room
        if (prio > holder_prio) begin
          holder_prio = prio;
          r.boost_valid = 1'b1;
          r.boost_task = holder_id;
          r.boost_priority = prio;
        end
        if (waiters.size() < WAIT_DEPTH) begin
          waiters.push_back('{id: id, prio: prio});
          r.status = ST_WAITING;
        end else begin
          r.status = ST_FULL;
        end
      end
    end else if (!is_holder) begin
      r.status = ST_NOT_OWNER;
    end else begin
      if (depth != 8'd0) depth--;
      if (depth != 8'd0) begin
        r.status = ST_HELD;
      end else if (waiters.size() > 0) begin
        // highest priority wins, earliest among equals
        best = 0;
        for (int i = 1; i < waiters.size(); i++) begin
          if (waiters[i].prio > waiters[best].prio) best = i;
        end
        holder_id = waiters[best].id;
        holder_prio = waiters[best].prio;
        depth = 8'd1;
        waiters.delete(best);
        r.wake_valid = 1'b1;
        r.wake_task = holder_id;
        r.status = ST_RELEASED;
      end else begin
        held = 1'b0;
        holder_id = '0;
        holder_prio = '0;
        r.status = ST_RELEASED;
      end
    end
    r.nest_depth = depth;
    return r;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    mutex_result_t want;
    if (!rst_n) begin
      held = 1'b0;
      holder_id = '0;
      holder_prio = '0;
      depth = '0;
      waiters.delete();
      expected_results.delete();
      mismatches = 0;
      outstanding = 0;
      checked = 0;
    end else begin
      // retire the result first: it can never belong to a request taken at this edge
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d", out_status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("wake_valid", want.wake_valid, out_wake_valid);
          compare_field("wake_task", want.wake_task, out_wake_task);
          compare_field("boost_valid", want.boost_valid, out_boost_valid);
          compare_field("boost_task", want.boost_task, out_boost_task);
          compare_field("boost_priority", want.boost_priority, out_boost_priority);
          compare_field("nest_depth", want.nest_depth, out_nest_depth);
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request(in_cmd, in_task_id, in_task_priority));
      end
      outstanding = expected_results.size();
    end
  end

endmodule

/* dv/tb_priority_inheritance_mutex.sv */
`timescale 1ns / 100ps
// Testbench top for the priority inheritance mutex: clock, reset, request stimulus and verdict.
module tb_priority_inheritance_mutex;
  import pim_pkg::*;

  localparam int WAIT_DEPTH  = 16;
  localparam int QUIET_LIMIT = 4000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_cmd = CMD_LOCK;
  logic [7:0] in_task_id = '0;
  logic [7:0] in_task_priority = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [2:0] out_status;
  logic       out_wake_valid;
  logic [7:0] out_wake_task;
  logic       out_boost_valid;
  logic [7:0] out_boost_task;
  logic [7:0] out_boost_priority;
  logic [7:0] out_nest_depth;

  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         sent = 0;
  int         quiet_cycles = 0;
  int         mismatches;
  int         outstanding;
  int         checked;
  logic [7:0] task_pool [6];

  priority_inheritance_mutex #(.WAIT_DEPTH(WAIT_DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_task_id        (in_task_id),
    .in_task_priority  (in_task_priority),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_wake_valid    (out_wake_valid),
    .out_wake_task     (out_wake_task),
    .out_boost_valid   (out_boost_valid),
    .out_boost_task    (out_boost_task),
    .out_boost_priority(out_boost_priority),
    .out_nest_depth    (out_nest_depth)
  );

  pim_result_checker #(.WAIT_DEPTH(WAIT_DEPTH)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_task_id        (in_task_id),
    .in_task_priority  (in_task_priority),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_wake_valid    (out_wake_valid),
    .out_wake_task     (out_wake_task),
    .out_boost_valid   (out_boost_valid),
    .out_boost_task    (out_boost_task),
    .out_boost_priority(out_boost_priority),
    .out_nest_depth    (out_nest_depth),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .checked           (checked)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** priority_inheritance_mutex: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic cmd, input logic [7:0] id, input logic [7:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_task_id <= id;
    in_task_priority <= prio;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // Batches of requests from a small set of tasks, so that holders do come back to unlock.
  task automatic random_requests(input int count);
    int         span;
    int         lock_pct;
    int         prio_top;
    logic       cmd;
    logic [7:0] id;
    while (count > 0) begin
      span = $urandom_range(6, 1);
      lock_pct = 25 + 20 * $urandom_range(2);
      prio_top = ($urandom_range(3) == 0) ? 3 : 255;
      for (int k = 0; k < 40 && count > 0; k++) begin
        cmd = ($urandom_range(99) < lock_pct) ? CMD_LOCK : CMD_UNLOCK;
        if (cmd == CMD_UNLOCK && $urandom_range(19) == 0) begin
          id = 8'($urandom_range(255));
        end else if ($urandom_range(99) < 85) begin
          id = task_pool[$urandom_range(span - 1)];
        end else begin
          id = task_pool[$urandom_range(5)];
        end
        send_request(cmd, id, 8'($urandom_range(prio_top)));
        count--;
      end
    end
  endtask

  initial begin
    logic [7:0] seed_id;
    seed_id = 8'($urandom_range(255));
    task_pool[0] = seed_id;
    task_pool[1] = ~seed_id;
    for (int i = 2; i < 6; i++) task_pool[i] = 8'($urandom_range(255));

    send_idle_pct = 12;
    stall_pct = 75;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ownership, nesting, boosts, ties and hand-off order
    send_request(CMD_UNLOCK, 8'h5A, 8'h00);
    send_request(CMD_LOCK,   8'h00, 8'h00);
    send_request(CMD_LOCK,   8'h00, 8'hFF);
    send_request(CMD_LOCK,   8'hFF, 8'hFF);
    send_request(CMD_LOCK,   8'h81, 8'h7F);
    send_request(CMD_LOCK,   8'h7E, 8'hFF);
    send_request(CMD_LOCK,   8'hFF, 8'h10);
    send_request(CMD_UNLOCK, 8'h81, 8'h00);
    send_request(CMD_UNLOCK, 8'h00, 8'h00);
    send_request(CMD_UNLOCK, 8'h00, 8'h00);
    send_request(CMD_UNLOCK, 8'hFF, 8'h00);
    send_request(CMD_UNLOCK, 8'h7E, 8'h00);
    send_request(CMD_UNLOCK, 8'h81, 8'h00);
    send_request(CMD_UNLOCK, 8'hFF, 8'h00);

    // fill the wait list, overflow it with a boosting request, then drain it in order
    send_request(CMD_LOCK, 8'h3C, 8'h01);
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      send_request(CMD_LOCK, 8'(i * 16 + 7), 8'(8'hFE - 3 * i));
    end
    send_request(CMD_LOCK, 8'hC3, 8'hFF);
    send_request(CMD_UNLOCK, 8'h3C, 8'h00);
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      send_request(CMD_UNLOCK, 8'(i * 16 + 7), 8'h00);
    end

    // nest to the depth limit and past it, then unwind and hand over
    for (int i = 0; i < 257; i++) send_request(CMD_LOCK, 8'hA5, 8'h20);
    send_request(CMD_LOCK, 8'h5A, 8'hC0);
    for (int i = 0; i < 255; i++) send_request(CMD_UNLOCK, 8'hA5, 8'h00);
    send_request(CMD_UNLOCK, 8'h5A, 8'h00);

    random_requests(380);
    send_idle_pct = 75;
    stall_pct = 12;
    random_requests(390);
    send_idle_pct = 0;
    stall_pct = 0;
    random_requests(390);
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (WAIT_DEPTH + 8) @(posedge clk);

    $display("Run covered %0d requests: corner cases, a full wait list, nesting past the limit,",
             sent);
    $display("and random lock/unlock batches under three idle and stall mixes; %0d results checked.",
             checked);
    if (mismatches == 0) begin
      $display("** priority_inheritance_mutex: PASSED **");
    end else begin
      $display("** priority_inheritance_mutex: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pim_pkg.sv
hw/rtl/pim_cell.sv
hw/rtl/priority_inheritance_mutex.sv
dv/pim_result_checker.sv
dv/tb_priority_inheritance_mutex.sv
